// File: rtl/core/gfcr_pkg.sv
package gfcr_pkg;

  // Frame geometry
  localparam int RX_CAPACITY = 32;
  localparam int HEAD_DEPTH  = 3;
  localparam int RX_LEN_W    = $clog2(RX_CAPACITY + 1);
  localparam int COUNT_W     = 16;
  localparam int REPLY_LEN   = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [COUNT_W-1:0] GAP_LIMIT_RST = 16'd13;

  // Item kinds; the fourth code is an idle beat
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_RX_BYTE = 2'd1;
  localparam logic [1:0] FUNC_TX_SLOT = 2'd2;

  // Command codes
  localparam logic [7:0] CMD_ECHO   = 8'h01;
  localparam logic [7:0] CMD_SPEED  = 8'h02;
  localparam logic [7:0] CMD_SDIFF  = 8'h03;
  localparam logic [7:0] CMD_TORQUE = 8'h04;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_data;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_data;
    logic       transmitting;
    logic       speed_diff_request;
    logic       torque_request;
  } out_item_t;

endpackage

// File: rtl/core/gfcr_in_stage.sv
module gfcr_in_stage
  import gfcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     item_valid,
  input  logic     item_take,
  output in_item_t item
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // Accept a beat when empty or when the held one moves on this cycle
  assign in_ready  = !valid_r || item_take;
  assign valid_nxt = (in_valid && in_ready) || (valid_r && !item_take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the payload until it is taken
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/core/gfcr_engine.sv
module gfcr_engine
  import gfcr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [COUNT_W-1:0] gap_limit,
  input  logic               item_valid,
  output logic               item_take,
  input  in_item_t           item,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  logic [COUNT_W-1:0]  silence_r, silence_nxt;
  logic                frame_open_r, frame_open_nxt;
  logic [7:0]          rx_head_r [HEAD_DEPTH];
  logic [RX_LEN_W-1:0] rx_length_r, rx_length_nxt;
  logic                tx_mode_r, tx_mode_nxt;
  logic [7:0]          reply_r [REPLY_LEN];
  logic [1:0]          reply_len_r, reply_len_nxt;
  logic [1:0]          reply_idx_r, reply_idx_nxt;
  logic                sdiff_r, sdiff_nxt;
  logic                torque_r, torque_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_r, out_nxt;

  logic                frame_end;
  logic                is_echo, is_speed, is_sdiff, is_torque;
  logic                head_wr;
  logic [RX_LEN_W-1:0] rx_len_a;
  logic [1:0]          reply_len_a, reply_idx_a;
  logic                tx_mode_a;
  logic                sent;
  logic [7:0]          sent_data;

  // Move an item into the result register when that register frees up
  assign item_take = item_valid && (!out_valid_r || out_ready);

  // Close the frame on a long enough gap and decode it
  assign frame_end = frame_open_r && (silence_r > gap_limit);
  assign is_echo   = (rx_head_r[0] == CMD_ECHO)   && (rx_length_r == RX_LEN_W'(3));
  assign is_speed  = (rx_head_r[0] == CMD_SPEED)  && (rx_length_r == RX_LEN_W'(1));
  assign is_sdiff  = (rx_head_r[0] == CMD_SDIFF)  && (rx_length_r == RX_LEN_W'(1));
  assign is_torque = (rx_head_r[0] == CMD_TORQUE) && (rx_length_r == RX_LEN_W'(1));

  assign tx_mode_a   = frame_end ? 1'b1 : tx_mode_r;
  assign rx_len_a    = frame_end ? '0 : rx_length_r;
  assign reply_idx_a = frame_end ? 2'd0 : reply_idx_r;
  assign reply_len_a = frame_end ? ((is_echo || is_speed) ? 2'(REPLY_LEN) : 2'd0)
                                 : reply_len_r;

  // Step state for one item
  always_comb begin
    silence_nxt    = silence_r;
    frame_open_nxt = frame_open_r && !frame_end;
    rx_length_nxt  = rx_len_a;
    tx_mode_nxt    = tx_mode_a;
    reply_len_nxt  = reply_len_a;
    reply_idx_nxt  = reply_idx_a;
    sdiff_nxt      = sdiff_r || (frame_end && is_sdiff);
    torque_nxt     = torque_r || (frame_end && is_torque);
    head_wr        = 1'b0;
    sent           = 1'b0;
    sent_data      = 8'h00;
    case (item.func)
      FUNC_TICK: begin
        if (silence_r != COUNT_MAX) begin
          silence_nxt = silence_r + COUNT_W'(1);
        end
      end
      FUNC_RX_BYTE: begin
        if (!tx_mode_a) begin
          frame_open_nxt = 1'b1;
          silence_nxt    = '0;
          head_wr        = (rx_len_a < RX_LEN_W'(HEAD_DEPTH));
          if (rx_len_a < RX_LEN_W'(RX_CAPACITY)) begin
            rx_length_nxt = rx_len_a + RX_LEN_W'(1);
          end
        end
      end
      FUNC_TX_SLOT: begin
        if (tx_mode_a) begin
          if (reply_idx_a < reply_len_a) begin
            sent          = 1'b1;
            sent_data     = reply_r[reply_idx_a];
            reply_idx_nxt = reply_idx_a + 2'd1;
          end else begin
            reply_len_nxt = 2'd0;
            reply_idx_nxt = 2'd0;
            tx_mode_nxt   = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Bytes sent from a reply built this very item come from the decode
  logic [7:0] reply_fresh [REPLY_LEN];
  always_comb begin
    reply_fresh[0] = is_echo ? rx_head_r[0] : CMD_SPEED;
    reply_fresh[1] = is_echo ? rx_head_r[1] : 8'h00;
    reply_fresh[2] = is_echo ? rx_head_r[2] : 8'h00;
  end

  always_comb begin
    out_nxt                    = out_r;
    out_valid_nxt              = out_valid_r && !out_ready;
    if (item_take) begin
      out_valid_nxt              = 1'b1;
      out_nxt.tx_valid           = sent;
      out_nxt.tx_data            = (sent && frame_end) ? reply_fresh[reply_idx_a] : sent_data;
      out_nxt.transmitting       = tx_mode_nxt;
      out_nxt.speed_diff_request = sdiff_nxt;
      out_nxt.torque_request     = torque_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      silence_r    <= '0;
      frame_open_r <= 1'b0;
      rx_length_r  <= '0;
      tx_mode_r    <= 1'b0;
      reply_len_r  <= 2'd0;
      reply_idx_r  <= 2'd0;
      sdiff_r      <= 1'b0;
      torque_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (item_take) begin
        silence_r    <= silence_nxt;
        frame_open_r <= frame_open_nxt;
        rx_length_r  <= rx_length_nxt;
        tx_mode_r    <= tx_mode_nxt;
        reply_len_r  <= reply_len_nxt;
        reply_idx_r  <= reply_idx_nxt;
        sdiff_r      <= sdiff_nxt;
        torque_r     <= torque_nxt;
      end
    end
  end

  // Payload registers: frame head, reply bytes, result
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (item_take && head_wr) begin
      rx_head_r[rx_len_a[1:0]] <= item.rx_data;
    end
    if (item_take && frame_end && (is_echo || is_speed)) begin
      reply_r[0] <= reply_fresh[0];
      reply_r[1] <= reply_fresh[1];
      reply_r[2] <= reply_fresh[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Reply cursor never runs past the reply
  a_idx_in_reply: assert property (@(posedge clk) disable iff (!rst_n)
    reply_idx_r <= reply_len_r)
    else $error("reply index beyond reply length");

  // Receive mode carries no pending reply
  a_rx_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    !tx_mode_r |-> (reply_idx_r == 2'd0) && (reply_len_r == 2'd0))
    else $error("reply state left over in receive mode");

  // No frame stays open while transmitting
  a_tx_closed: assert property (@(posedge clk) disable iff (!rst_n)
    tx_mode_r |-> !frame_open_r)
    else $error("frame open in transmit mode");

  // A sent byte leaves the line in transmit
  a_sent_tx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.tx_valid |-> out_r.transmitting)
    else $error("byte sent while line in receive");

  // Sticky flags drop only at reset
  a_sticky: assert property (@(posedge clk)
    rst_n && $past(rst_n) |-> !$fell(sdiff_r) && !$fell(torque_r))
    else $error("sticky request flag cleared");

  // Frame length saturates at the capacity
  a_rx_cap: assert property (@(posedge clk) disable iff (!rst_n)
    rx_length_r <= RX_LEN_W'(RX_CAPACITY))
    else $error("frame length beyond capacity");

endmodule

// File: rtl/core/gap_framed_command_responder_core.sv
// A beat accepted into the input register moves on into the result register
// once that register is empty or is being emptied through out_ready.
// Throughput: one beat per cycle while out_ready is high; the input register and
// the result register each pass one beat a cycle, and the input side keeps taking
// beats while a result waits, until the input register is full too.
// Reset (rst_n low, synchronous): empties both registers, closes any frame,
// returns the line to receive, clears the sticky flags, gap limit back to 13.
module gap_framed_command_responder_core
  import gfcr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data
);

  logic [COUNT_W-1:0] gap_limit_r;
  logic               item_valid;
  logic               item_take;
  in_item_t           item;

  // Gap limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= GAP_LIMIT_RST;
    end else if (cfg_wr_en) begin
      gap_limit_r <= cfg_wr_data;
    end
  end

  gfcr_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item)
  );

  gfcr_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .gap_limit  (gap_limit_r),
    .item_valid (item_valid),
    .item_take  (item_take),
    .item       (item),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// File: bench/gfcr_checker.sv
module gfcr_checker
  import gfcr_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  in_item_t           in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  out_item_t          out_data,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  output int                 fail_count,
  output int                 replies_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the responder state
  logic [COUNT_W-1:0] gap_limit;
  logic [COUNT_W-1:0] silence;
  logic               frame_open;
  logic               line_tx;
  logic               sdiff_flag;
  logic               torque_flag;
  logic [7:0]         head [HEAD_DEPTH];
  logic [7:0]         reply [REPLY_LEN];
  int                 rx_len;
  int                 reply_len;
  int                 reply_pos;

  // Results predicted but not yet seen on the output
  out_item_t          owed_q[$];

  initial fail_count = 0;

  // Decode a closed frame into a reply or a sticky flag
  function automatic void decode_frame();
    reply_len = 0;
    if (head[0] == CMD_ECHO && rx_len == 3) begin
      for (int i = 0; i < REPLY_LEN; i++) reply[i] = head[i];
      reply_len = REPLY_LEN;
    end else if (head[0] == CMD_SPEED && rx_len == 1) begin
      reply[0] = CMD_SPEED;
      reply[1] = 8'h00;
      reply[2] = 8'h00;
      reply_len = REPLY_LEN;
    end else if (head[0] == CMD_SDIFF && rx_len == 1) begin
      sdiff_flag = 1'b1;
    end else if (head[0] == CMD_TORQUE && rx_len == 1) begin
      torque_flag = 1'b1;
    end
  endfunction

  // Advance the shadow state by one beat and return its result
  function automatic out_item_t respond(in_item_t beat);
    out_item_t r;
    r = '0;
    // close the frame once the silence outlasts the gap limit
    if (frame_open && silence > gap_limit) begin
      frame_open = 1'b0;
      decode_frame();
      rx_len = 0;
      reply_pos = 0;
      line_tx = 1'b1;
    end
    case (beat.func)
      FUNC_TICK: begin
        if (silence != COUNT_MAX) silence = silence + 1'b1;
      end
      FUNC_RX_BYTE: begin
        // drop bytes while the line is turned around
        if (!line_tx) begin
          frame_open = 1'b1;
          silence = '0;
          if (rx_len < HEAD_DEPTH) head[rx_len] = beat.rx_data;
          if (rx_len < RX_CAPACITY) rx_len++;
        end
      end
      FUNC_TX_SLOT: begin
        if (line_tx) begin
          if (reply_pos < reply_len && reply_pos < REPLY_LEN) begin
            r.tx_valid = 1'b1;
            r.tx_data = reply[reply_pos];
            reply_pos++;
          end else begin
            reply_len = 0;
            reply_pos = 0;
            line_tx = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.transmitting = line_tx;
    r.speed_diff_request = sdiff_flag;
    r.torque_request = torque_flag;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      fail_count++;
    end
  endtask

  // Track config writes, predict on input beats, compare on output beats
  always @(posedge clk) begin : watch
    out_item_t want;
    if (!rst_n) begin
      gap_limit = GAP_LIMIT_RST;
      silence = '0;
      frame_open = 1'b0;
      line_tx = 1'b0;
      sdiff_flag = 1'b0;
      torque_flag = 1'b0;
      rx_len = 0;
      reply_len = 0;
      reply_pos = 0;
      owed_q.delete();
    end else begin
      if (cfg_wr_en) gap_limit = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          check_field("tx_valid", 8'(want.tx_valid), 8'(out_data.tx_valid));
          check_field("tx_data", want.tx_data, out_data.tx_data);
          check_field("transmitting", 8'(want.transmitting), 8'(out_data.transmitting));
          check_field("speed_diff_request", 8'(want.speed_diff_request),
                      8'(out_data.speed_diff_request));
          check_field("torque_request", 8'(want.torque_request),
                      8'(out_data.torque_request));
        end
      end
      if (in_valid && in_ready) owed_q.push_back(respond(in_data));
    end
    replies_owed = owed_q.size();
  end

endmodule

// File: bench/testbench.sv
module testbench
  import gfcr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_IDLE = 2'd3;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int STALL_LIMIT    = 1000;
  localparam int PHASE_BEATS    = 60;
  localparam int GAP_PLAN [5]   = '{1, 13, 3, 0, 6};

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_ready;
  out_item_t          out_data;
  logic               cfg_wr_en;
  logic [COUNT_W-1:0] cfg_wr_data;

  int fail_count;
  int replies_owed;
  int beats_sent = 0;
  int gap_now = 13;
  int stall_cycles = 0;
  bit no_idle = 1'b0;
  bit rx_hold_req = 1'b0;

  always #10 clk = ~clk;

  gap_framed_command_responder_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  gfcr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .fail_count   (fail_count),
    .replies_owed (replies_owed)
  );

  // Abort when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(99) >= 11);
      end
    end
  end

  // Offer one beat, with an occasional idle gap first, and hold it until taken
  task automatic send_beat(input logic [1:0] fn, input logic [7:0] dat);
    in_item_t beat;
    if (!no_idle) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    beat.func = fn;
    beat.rx_data = dat;
    in_valid <= 1'b1;
    in_data <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (fn != FUNC_IDLE) beats_sent++;
  endtask

  // Stop offering and wait until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (replies_owed != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_gap_limit(input logic [COUNT_W-1:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    gap_now = int'(value);
  endtask

  // One command frame: bytes with short pauses, a closing silence, then
  // enough transmit slots to drain any reply; sometimes just random beats
  task automatic send_frame();
    logic [7:0] frame_q[$];
    int kind;
    kind = $urandom_range(0, 11);
    if (kind >= 10) begin
      repeat ($urandom_range(1, 6)) send_beat(2'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    case (kind)
      0, 1, 2: begin
        frame_q.push_back(CMD_ECHO);
        frame_q.push_back(8'($urandom));
        frame_q.push_back(8'($urandom));
      end
      3: frame_q.push_back(CMD_SPEED);
      4: frame_q.push_back(CMD_SDIFF);
      5: frame_q.push_back(CMD_TORQUE);
      6, 7: begin
        // long frames overrun the head buffer and saturate the length
        repeat ($urandom_range(1, 40)) frame_q.push_back(8'($urandom));
      end
      8: begin
        frame_q.push_back(CMD_ECHO);
        repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
      end
      default: begin
        case ($urandom_range(2))
          0: frame_q.push_back(CMD_SPEED);
          1: frame_q.push_back(CMD_SDIFF);
          default: frame_q.push_back(CMD_TORQUE);
        endcase
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
      end
    endcase
    foreach (frame_q[i]) begin
      send_beat(FUNC_RX_BYTE, frame_q[i]);
      // keep pauses within the gap limit so the frame stays open
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(0, gap_now)) send_beat(FUNC_TICK, 8'($urandom));
      end
      if ($urandom_range(9) == 0) begin
        send_beat($urandom_range(1) ? FUNC_IDLE : FUNC_TX_SLOT, 8'($urandom));
      end
    end
    repeat (gap_now + 1 + $urandom_range(0, 2)) send_beat(FUNC_TICK, 8'($urandom));
    repeat (4 + $urandom_range(0, 2)) begin
      if ($urandom_range(9) == 0) send_beat(FUNC_RX_BYTE, 8'($urandom));
      send_beat(FUNC_TX_SLOT, 8'($urandom));
    end
  endtask

  initial begin
    int target;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero gap limit so a single tick ends a frame
    set_gap_limit(16'd0);
    // echo with extreme bytes
    send_beat(FUNC_RX_BYTE, CMD_ECHO);
    send_beat(FUNC_RX_BYTE, 8'hFF);
    send_beat(FUNC_RX_BYTE, 8'h00);
    send_beat(FUNC_TICK, 8'hFF);
    repeat (4) send_beat(FUNC_TX_SLOT, 8'h00);
    // speed query, with a byte arriving mid-reply
    send_beat(FUNC_RX_BYTE, CMD_SPEED);
    send_beat(FUNC_TICK, 8'h00);
    send_beat(FUNC_TX_SLOT, 8'hFF);
    send_beat(FUNC_RX_BYTE, 8'h55);
    repeat (3) send_beat(FUNC_TX_SLOT, 8'h00);
    // speed-diff flag: empty reply, first slot turns the line back
    send_beat(FUNC_RX_BYTE, CMD_SDIFF);
    send_beat(FUNC_TICK, 8'h00);
    send_beat(FUNC_TX_SLOT, 8'h00);
    // torque flag, frame closed by an idle beat
    send_beat(FUNC_RX_BYTE, CMD_TORQUE);
    send_beat(FUNC_TICK, 8'h00);
    send_beat(FUNC_IDLE, 8'hFF);
    send_beat(FUNC_TX_SLOT, 8'h00);
    // slot while receiving, then an idle beat
    send_beat(FUNC_TX_SLOT, 8'hFF);
    send_beat(FUNC_IDLE, 8'hAA);

    // Random frames across several gap limits
    for (int p = 0; p < 5; p++) begin
      set_gap_limit(16'(GAP_PLAN[p]));
      no_idle = (p == 3);
      if (p == 1) rx_hold_req = 1'b1;
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) send_frame();
    end
    no_idle = 1'b0;

    // Widest gap limit: the count never exceeds it, so the frame stays open
    set_gap_limit(16'hFFFF);
    send_beat(FUNC_RX_BYTE, CMD_SPEED);
    repeat (40) send_beat(FUNC_TICK, 8'($urandom));
    send_beat(FUNC_TX_SLOT, 8'h00);

    // Lower the limit; the still-open frame closes on the next beat
    set_gap_limit(16'd20);
    repeat (4) send_beat(FUNC_TX_SLOT, 8'($urandom));

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/gfcr_pkg.sv
rtl/core/gfcr_in_stage.sv
rtl/core/gfcr_engine.sv
rtl/core/gap_framed_command_responder_core.sv
bench/gfcr_checker.sv
bench/testbench.sv
